// ----- rtl/core/wts_pkg.sv -----
`default_nettype none

package wts_pkg;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_RESTART = 2'd1,
        KIND_TICK    = 2'd2
    } wts_kind_t;

    // controller states
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } wts_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } wts_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } wts_status_t;

    // command byte codes and ranges
    localparam logic [7:0] CMD_JUMP       = 8'h7F;
    localparam logic [7:0] CMD_BACK       = 8'h7E;
    localparam logic [7:0] CMD_ABS_LIMIT  = 8'h60;
    localparam logic [7:0] CMD_REL_BASE   = 8'h80;
    localparam logic [7:0] CMD_REL_LIMIT  = 8'hE0;

    // wave byte ranges
    localparam logic [7:0] WAVE_PLAIN_LOW = 8'h10;
    localparam logic [7:0] WAVE_MASK_LOW  = 8'hE0;
    localparam logic [7:0] WAVE_MASK_HIGH = 8'hF0;
    localparam logic [7:0] WAVE_DELAY_MAX = 8'h0F;

    // reset values
    localparam logic [7:0] WAVEFORM_RESET = 8'h11;
    localparam logic [3:0] DELAY_RESET    = 4'd1;

endpackage

`default_nettype wire

// ----- rtl/core/wts_ctrl.sv -----
`default_nettype none

module wts_ctrl
    import wts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wts_status_t      status,
    output wts_cmd_t         cmd
);

    wts_state_t state_reg;
    wts_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // wait here while the previous result is still held
                if (!status.out_busy) begin
                    cmd.execute = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/wts_datapath.sv -----
`default_nettype none

module wts_datapath
    import wts_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic [23:0] s_tdata,
    input  wts_cmd_t         cmd,
    output wts_status_t      status,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tuser,
    output logic [15:0]      m_tdata
);

    localparam int         AW     = $clog2(TABLE_DEPTH);
    localparam logic [8:0] DEPTH9 = 9'(TABLE_DEPTH);

    // table storage
    logic [7:0] command_mem [TABLE_DEPTH];
    logic [7:0] wave_mem    [TABLE_DEPTH];
    logic [7:0] rd_cmd_reg;
    logic [7:0] rd_wave_reg;

    // captured item
    logic [1:0] kind_reg;
    logic [7:0] idx_reg;
    logic [7:0] cmd_byte_reg;
    logic [7:0] wave_byte_reg;

    // player state
    logic [8:0] length_reg;
    logic [8:0] pos_reg,       pos_next;
    logic [3:0] delay_reg,     delay_next;
    logic [3:0] remain_reg,    remain_next;
    logic [7:0] waveform_reg,  waveform_next;
    logic [6:0] transpose_reg, transpose_next;
    logic       running_next;

    // output register
    logic       out_valid_reg;
    logic       out_running_reg;
    logic [7:0] out_waveform_reg;
    logic [6:0] out_transpose_reg;

    logic [8:0] eff_len;
    logic [8:0] loop_pos;
    logic       load_ok;

    assign eff_len = (length_reg > DEPTH9) ? DEPTH9 : length_reg;
    assign load_ok = ({1'b0, idx_reg} < DEPTH9);

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg      <= s_tuser;
            idx_reg       <= s_tdata[7:0];
            cmd_byte_reg  <= s_tdata[15:8];
            wave_byte_reg <= s_tdata[23:16];
        end
    end

    // table write on load, registered read at the read position
    always_ff @(posedge aclk) begin
        if (cmd.execute && (kind_reg == KIND_LOAD) && load_ok) begin
            command_mem[idx_reg[AW-1:0]] <= cmd_byte_reg;
            wave_mem[idx_reg[AW-1:0]]    <= wave_byte_reg;
        end
        rd_cmd_reg  <= command_mem[pos_reg[AW-1:0]];
        rd_wave_reg <= wave_mem[pos_reg[AW-1:0]];
    end

    // loop target with wrap
    always_comb begin
        if (rd_cmd_reg == CMD_BACK) begin
            loop_pos = (pos_reg != 9'd0) ? (pos_reg - 9'd1) : 9'd0;
        end else begin
            loop_pos = {1'b0, rd_wave_reg};
        end
        if (loop_pos >= eff_len) begin
            loop_pos = 9'd0;
        end
    end

    // player step
    always_comb begin
        pos_next       = pos_reg;
        delay_next     = delay_reg;
        remain_next    = remain_reg;
        waveform_next  = waveform_reg;
        transpose_next = transpose_reg;
        running_next   = 1'b0;
        case (kind_reg)
            KIND_RESTART: begin
                pos_next    = 9'd0;
                delay_next  = DELAY_RESET;
                remain_next = 4'd0;
            end
            KIND_TICK: begin
                if ((eff_len == 9'd0) || (pos_reg >= eff_len)) begin
                    running_next = 1'b0;
                end else if (remain_reg != 4'd0) begin
                    running_next = 1'b1;
                    remain_next  = remain_reg - 4'd1;
                end else if ((rd_cmd_reg == CMD_JUMP) || (rd_cmd_reg == CMD_BACK)) begin
                    running_next = 1'b1;
                    pos_next     = loop_pos;
                end else begin
                    running_next = 1'b1;
                    // transpose from command byte
                    if (rd_cmd_reg < CMD_ABS_LIMIT) begin
                        transpose_next = rd_cmd_reg[6:0];
                    end else if ((rd_cmd_reg >= CMD_REL_BASE) && (rd_cmd_reg < CMD_REL_LIMIT)) begin
                        transpose_next = rd_cmd_reg[6:0];
                    end
                    // waveform or delay from wave byte
                    if ((rd_wave_reg >= WAVE_PLAIN_LOW) && (rd_wave_reg < WAVE_MASK_LOW)) begin
                        waveform_next = rd_wave_reg;
                    end else if ((rd_wave_reg >= WAVE_MASK_LOW)
                                 && (rd_wave_reg < WAVE_MASK_HIGH)) begin
                        waveform_next = {4'd0, rd_wave_reg[3:0]};
                    end else if ((rd_wave_reg != 8'd0) && (rd_wave_reg <= WAVE_DELAY_MAX)) begin
                        delay_next = rd_wave_reg[3:0];
                    end
                    remain_next = delay_next - 4'd1;
                    pos_next    = pos_reg + 9'd1;
                end
            end
            default: begin
                running_next = 1'b0;
            end
        endcase
    end

    // state and config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg    <= 9'd0;
            pos_reg       <= 9'd0;
            delay_reg     <= DELAY_RESET;
            remain_reg    <= 4'd0;
            waveform_reg  <= WAVEFORM_RESET;
            transpose_reg <= 7'd0;
        end else begin
            if (cfg_we) begin
                length_reg <= cfg_wdata;
            end
            if (cmd.execute) begin
                pos_reg       <= pos_next;
                delay_reg     <= delay_next;
                remain_reg    <= remain_next;
                waveform_reg  <= waveform_next;
                transpose_reg <= transpose_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.execute) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            out_running_reg   <= running_next;
            out_waveform_reg  <= waveform_next;
            out_transpose_reg <= transpose_next;
        end
    end

    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tuser         = out_running_reg;
    assign m_tdata         = {1'b0, out_transpose_reg, out_waveform_reg};

endmodule

`default_nettype wire

// ----- rtl/core/wave_table_sequencer_top.sv -----
`default_nettype none

// Wave table sequencer: plays an instrument wave table one frame tick at a
// time. Each input transaction (load entry, restart, frame tick) yields one
// result transaction with the running flag and the current waveform and
// transpose. An item is handled in a read step, the synchronous read of the
// table entry at the read position, then an update step into the output
// register. The next item is accepted right after; the update step is held
// only while the previous result still sits unread in the output register.
// table_length may be written only while no transaction is in flight.

module wave_table_sequencer_top
    import wts_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // table_length register
    input  wire logic        cfg_we,
    input  wire logic [8:0]  cfg_wdata,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // entry_index, entry_command, entry_wave
    input  wire logic [1:0]  s_tuser,   // kind
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // waveform, transpose, zero pad
    output logic             m_tuser    // running
);

    wts_cmd_t    cmd;
    wts_status_t status;

    wts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wts_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    // one item at a time: no accept in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted during update cycle");

    // a new result appears only out of the update cycle
    a_result_from_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised without an item in progress");

    // transpose stays in note range
    a_transpose_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:8] < 7'd96))
        else $error("transpose out of range");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import wts_pkg::*;

    localparam int CYCLE_LIMIT = 1_200_000;
    localparam int ITEM_TARGET = 1950;

    // one input transaction as the driver sends it
    typedef struct packed {
        wts_kind_t  kind;
        logic [7:0] entry_index;
        logic [7:0] entry_command;
        logic [7:0] entry_wave;
    } seq_item_t;

    // one result transaction
    typedef struct packed {
        logic       running;
        logic [7:0] waveform;
        logic [6:0] transpose;
    } voice_state_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [8:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;

    seq_item_t    pending_items[$];
    voice_state_t expected_voice[$];
    seq_item_t    drive_item;
    voice_state_t got_voice;
    voice_state_t want_voice;

    int clock_cycles   = 0;
    int queued_count   = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int errors         = 0;
    int load_count     = 0;
    int restart_count  = 0;
    int tick_count     = 0;
    int stepping_count = 0;
    int length_writes  = 0;
    int send_gap       = 0;
    int hold_left      = 0;
    bit in_taken       = 1'b0;
    bit calm           = 1'b0;

    // shadow of the sequencer state
    logic [7:0] shadow_cmd[256];
    logic [7:0] shadow_wave[256];
    logic [8:0] shadow_length   = '0;
    logic [8:0] shadow_position = '0;
    logic [3:0] shadow_delay    = DELAY_RESET;
    logic [3:0] shadow_delay_left = '0;
    logic [7:0] shadow_waveform = WAVEFORM_RESET;
    logic [6:0] shadow_transpose = '0;

    wave_table_sequencer_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // interprets one frame tick against the shadow table, returns running
    function automatic logic play_frame();
        logic [8:0] span;
        logic [8:0] landing;
        logic [7:0] cmd_byte;
        logic [7:0] wave_byte;
        logic [7:0] offset;
        span = (shadow_length > 9'd256) ? 9'd256 : shadow_length;
        if (span == 9'd0 || shadow_position >= span) return 1'b0;
        if (shadow_delay_left != 4'd0) begin
            shadow_delay_left = shadow_delay_left - 4'd1;
            return 1'b1;
        end
        cmd_byte = shadow_cmd[shadow_position[7:0]];
        wave_byte = shadow_wave[shadow_position[7:0]];
        // loop commands move the read position only
        if (cmd_byte == CMD_JUMP || cmd_byte == CMD_BACK) begin
            if (cmd_byte == CMD_BACK)
                landing = (shadow_position > 9'd0) ? shadow_position - 9'd1 : 9'd0;
            else
                landing = {1'b0, wave_byte};
            shadow_position = (landing >= span) ? 9'd0 : landing;
            return 1'b1;
        end
        // transpose, absolute or from the relative range
        if (cmd_byte < CMD_ABS_LIMIT) begin
            shadow_transpose = cmd_byte[6:0];
        end else if (cmd_byte >= CMD_REL_BASE && cmd_byte < CMD_REL_LIMIT) begin
            offset = cmd_byte - CMD_REL_BASE;
            shadow_transpose = offset[6:0];
        end
        // waveform plain or masked, or a new frame delay
        if (wave_byte >= WAVE_PLAIN_LOW && wave_byte < WAVE_MASK_LOW) begin
            shadow_waveform = wave_byte;
        end else if (wave_byte >= WAVE_MASK_LOW && wave_byte < WAVE_MASK_HIGH) begin
            shadow_waveform = wave_byte - WAVE_MASK_LOW;
        end else if (wave_byte >= 8'd1 && wave_byte <= WAVE_DELAY_MAX) begin
            shadow_delay = wave_byte[3:0];
        end
        shadow_delay_left = shadow_delay - 4'd1;
        shadow_position = shadow_position + 9'd1;
        return 1'b1;
    endfunction

    function automatic voice_state_t apply_item(input seq_item_t item);
        voice_state_t voice;
        voice.running = 1'b0;
        case (item.kind)
            KIND_LOAD: begin
                shadow_cmd[item.entry_index] = item.entry_command;
                shadow_wave[item.entry_index] = item.entry_wave;
            end
            KIND_RESTART: begin
                shadow_position = '0;
                shadow_delay = DELAY_RESET;
                shadow_delay_left = '0;
            end
            KIND_TICK: voice.running = play_frame();
            default: ;
        endcase
        voice.waveform = shadow_waveform;
        voice.transpose = shadow_transpose;
        return voice;
    endfunction

    // mostly no pause, some short ones, a few long ones
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // input side: transaction accepted, predict its result
    // result side: compare with the oldest prediction
    always @(posedge aclk) begin
        clock_cycles++;
        in_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                in_taken = 1'b1;
                accepted_count++;
                drive_item.kind = wts_kind_t'(s_tuser);
                drive_item.entry_index = s_tdata[7:0];
                drive_item.entry_command = s_tdata[15:8];
                drive_item.entry_wave = s_tdata[23:16];
                want_voice = apply_item(drive_item);
                expected_voice.insert(expected_voice.size(), want_voice);
                case (drive_item.kind)
                    KIND_LOAD:    load_count++;
                    KIND_RESTART: restart_count++;
                    KIND_TICK: begin
                        tick_count++;
                        if (want_voice.running) stepping_count++;
                    end
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got_voice.running = m_tuser;
                got_voice.waveform = m_tdata[7:0];
                got_voice.transpose = m_tdata[14:8];
                if (expected_voice.size() == 0) begin
                    $error("result transaction with no prediction waiting");
                    errors++;
                end else begin
                    want_voice = expected_voice.pop_front();
                    checked_count++;
                    if (got_voice.running !== want_voice.running) begin
                        $error("running mismatch: expected %0d, got %0d",
                               want_voice.running, got_voice.running);
                        errors++;
                    end
                    if (got_voice.waveform !== want_voice.waveform) begin
                        $error("waveform mismatch: expected %h, got %h",
                               want_voice.waveform, got_voice.waveform);
                        errors++;
                    end
                    if (got_voice.transpose !== want_voice.transpose) begin
                        $error("transpose mismatch: expected %0d, got %0d",
                               want_voice.transpose, got_voice.transpose);
                        errors++;
                    end
                end
            end
        end
    end

    // input driver and result back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_items.size() != 0) begin
                drive_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {drive_item.entry_wave, drive_item.entry_command,
                            drive_item.entry_index};
                s_tuser <= drive_item.kind;
                send_gap <= pick_pause();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= 1'b1;
            hold_left <= pick_pause();
        end
    end

    task automatic queue_item(input wts_kind_t kind, input logic [7:0] idx,
                              input logic [7:0] cmd, input logic [7:0] wb);
        seq_item_t item;
        item.kind = kind;
        item.entry_index = idx;
        item.entry_command = cmd;
        item.entry_wave = wb;
        pending_items.insert(pending_items.size(), item);
        queued_count++;
    endtask

    task automatic queue_tick();
        queue_item(KIND_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    endtask

    task automatic queue_restart();
        queue_item(KIND_RESTART, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_voice.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // table_length write, only with nothing in flight
    task automatic set_table_length(input logic [8:0] len);
        wait_drained();
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= len;
        shadow_length = len;
        length_writes++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // a table entry with a realistic mix of commands for a table of span entries
    task automatic pick_entry(input int span, output logic [7:0] cmd,
                              output logic [7:0] wb);
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) cmd = 8'($urandom_range(0, 8'h5F));
        else if (r < 60) cmd = 8'($urandom_range(8'h80, 8'hDF));
        else if (r < 80) cmd = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(8'h60, 8'h7D))
                                                          : 8'($urandom_range(8'hE0, 8'hFF));
        else if (r < 91) cmd = CMD_JUMP;
        else cmd = CMD_BACK;
        r = $urandom_range(0, 99);
        if (cmd == CMD_JUMP)
            wb = (r < 70) ? 8'($urandom_range(0, span - 1)) : 8'($urandom_range(0, 255));
        else if (r < 35) wb = 8'($urandom_range(8'h10, 8'hDF));
        else if (r < 50) wb = 8'($urandom_range(8'hE0, 8'hEF));
        else if (r < 65) wb = 8'($urandom_range(1, 3));
        else if (r < 70) wb = 8'($urandom_range(4, 15));
        else if (r < 80) wb = ($urandom_range(0, 1) != 0) ? 8'h00
                                                         : 8'($urandom_range(8'hF0, 8'hFF));
        else wb = 8'($urandom_range(0, 255));
    endtask

    initial begin
        int phase;
        int len;
        int span;
        int steps;
        int r;
        logic [7:0] cmd;
        logic [7:0] wb;

        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_LOAD;
        m_tready = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        // empty table: ticks stop, loads still land
        queue_item(KIND_TICK, 8'h00, 8'h00, 8'h00);
        queue_item(KIND_LOAD, 8'd0, CMD_BACK, 8'h00);
        queue_item(KIND_LOAD, 8'd1, 8'h5F, 8'hEF);
        queue_item(KIND_LOAD, 8'd2, 8'hDF, 8'h02);
        queue_item(KIND_LOAD, 8'd3, 8'h60, 8'hF0);
        queue_item(KIND_LOAD, 8'd4, CMD_JUMP, 8'hFF);
        queue_item(KIND_LOAD, 8'd255, 8'hFF, 8'hFF);
        queue_item(KIND_TICK, 8'hFF, 8'hFF, 8'hFF);

        // step back at position zero, edit while playing, jump past the end
        set_table_length(9'd5);
        queue_item(KIND_TICK, 8'h00, 8'h00, 8'h00);
        queue_item(KIND_LOAD, 8'd0, 8'h80, 8'h01);
        repeat (8) queue_item(KIND_TICK, 8'h00, 8'h00, 8'h00);

        // shorter table: play runs off the end and stops
        set_table_length(9'd3);
        queue_item(KIND_RESTART, 8'h00, 8'h00, 8'h00);
        repeat (6) queue_item(KIND_TICK, 8'h00, 8'h00, 8'h00);

        // random phases: new length, fresh program, then mostly ticks
        phase = 0;
        while (queued_count < ITEM_TARGET) begin
            if (phase == 0) len = 256;
            else if (phase == 1) len = 1;
            else if (phase == 2) len = 511;
            else if (phase == 3) len = 0;
            else begin
                r = $urandom_range(0, 99);
                len = (r < 8) ? 0 : (r < 16) ? 256 : $urandom_range(1, 20);
            end
            span = (len > 256) ? 256 : len;
            set_table_length(len[8:0]);
            calm = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < span; i++) begin
                pick_entry(span, cmd, wb);
                queue_item(KIND_LOAD, i[7:0], cmd, wb);
            end
            if ($urandom_range(0, 3) != 0) queue_restart();
            steps = $urandom_range(40, 120);
            repeat (steps) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    queue_restart();
                end else if (r < 9 || (r < 12 && span == 0)) begin
                    queue_item(KIND_LOAD, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end else if (r < 12) begin
                    pick_entry(span, cmd, wb);
                    queue_item(KIND_LOAD, 8'($urandom_range(0, span - 1)), cmd, wb);
                end else begin
                    queue_tick();
                end
            end
            phase++;
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("run covered %0d transactions: %0d loads, %0d restarts, %0d ticks (%0d stepping)",
                 accepted_count, load_count, restart_count, tick_count, stepping_count);
        $display("%0d results checked over %0d table length settings incl. 0, 256 and oversized",
                 checked_count, length_writes);
        if (errors == 0 && expected_voice.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog
    initial begin
        while (clock_cycles < CYCLE_LIMIT) @(posedge aclk);
        $display("tb: failure");
        $finish;
    end

endmodule
